// ----- sv/fkp_pkg.sv -----
// Package with the payload types, FNV-1a constants and the hash step function.
`timescale 1ns / 1ps

package fkp_pkg;

   localparam int unsigned HASH_BITS   = 31;
   localparam int unsigned COUNT_BITS  = $clog2(HASH_BITS);
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_MULT = 32'd16777619;
   localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       byte_valid;
      logic       key_last;
   } req_type;

   typedef struct packed {
      logic [30:0] hash_value;
      logic [15:0] bucket;
   } rsp_type;

   // The prime is 2^24 + 403, so the product modulo 2^32 is a short sum of shifts.
   function automatic logic [31:0] fnv_step(input logic [31:0] hash, input logic [7:0] data);
      logic [31:0] x;
      x = hash ^ {24'd0, data};
      return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// ----- sv/fkp_front.sv -----
// Front end: accepts key bytes, keeps the running hash and pushes finished hashes.
`timescale 1ns / 1ps

module fkp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fkp_pkg::req_type        req_data,
   input  logic                    queue_full,
   output logic                    push,
   output logic [fkp_pkg::HASH_BITS-1:0] push_hash
);
   import fkp_pkg::*;

   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] hash_upd;
   logic        accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign hash_upd  = req_data.byte_valid ? fnv_step(hash_ff, req_data.key_byte) : hash_ff;
   assign push      = accept && req_data.key_last;
   assign push_hash = hash_upd[HASH_BITS-1:0];

   always_comb begin
      hash_in = hash_ff;
      if (accept) begin
         hash_in = req_data.key_last ? FNV_BASIS : hash_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

// ----- sv/fkp_queue.sv -----
// Short queue of finished hashes between the front end and the divider.
`timescale 1ns / 1ps

module fkp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [fkp_pkg::HASH_BITS-1:0]  push_hash,
   input  logic                           pop,
   output logic [fkp_pkg::HASH_BITS-1:0]  pop_hash,
   output logic                           full,
   output logic                           empty
);
   import fkp_pkg::*;

   logic [HASH_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_hash = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_hash;
      end
   end

endmodule

// ----- sv/fkp_back.sv -----
// Back end: restoring divider for the bucket index and the result register.
`timescale 1ns / 1ps

module fkp_back #(
   parameter int unsigned PARTITION_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [PARTITION_BITS-1:0]      partition_count,
   input  logic                           queue_empty,
   input  logic [fkp_pkg::HASH_BITS-1:0]  queue_hash,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fkp_pkg::rsp_type               rsp_data
);
   import fkp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [HASH_BITS-1:0]    hash_ff, hash_in;
   logic [HASH_BITS-1:0]    dividend_ff, dividend_in;
   logic [PARTITION_BITS-1:0] rem_ff, rem_in;
   logic [PARTITION_BITS:0] trial;
   logic [PARTITION_BITS:0] diff;
   logic [31:0]             rem_wide;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic                    out_free;

   assign trial    = {rem_ff, dividend_ff[HASH_BITS-1]};
   assign diff     = trial - {1'b0, partition_count};
   assign rem_wide = 32'(rem_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == ST_IDLE) && !queue_empty;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hash_in      = hash_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               hash_in     = queue_hash;
               dividend_in = queue_hash;
               rem_in      = '0;
               count_in    = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle, most significant first.
            rem_in      = (trial >= {1'b0, partition_count}) ?
                          diff[PARTITION_BITS-1:0] : trial[PARTITION_BITS-1:0];
            dividend_in = dividend_ff << 1;
            count_in    = count_ff + 1'b1;
            if (count_ff == COUNT_BITS'(HASH_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.hash_value = hash_ff;
               rsp_data_in.bucket     = (partition_count == '0) ? 16'd0 : rem_wide[15:0];
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      hash_ff     <= hash_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- sv/fnv1a_key_partitioner.sv -----
// Top level of the FNV-1a key partitioner: register, front end, queue and divider.
`timescale 1ns / 1ps

// Key bytes arrive one per transaction and are hashed at one byte per clock cycle by
// the front end while the queue is not full; a transaction marked last closes the key, and
// its 31-bit hash goes into a four-entry queue as the front end goes on with the next key.
// The back end loads each hash from the queue into a restoring divider that produces one
// quotient bit per cycle; after 31 division steps the hash and its remainder go into the
// output register once it is free, and only then does the back end pop the next hash.
// A partition count of zero gives bucket 0. Write the count only while no key result is
// outstanding.
module fnv1a_key_partitioner #(
   parameter int unsigned PARTITION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fkp_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fkp_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [PARTITION_BITS-1:0]  csr_wdata
);
   import fkp_pkg::*;

   logic [PARTITION_BITS-1:0] csr_partition_count_ff;
   logic                      push;
   logic [HASH_BITS-1:0]      push_hash;
   logic                      pop;
   logic [HASH_BITS-1:0]      pop_hash;
   logic                      queue_full;
   logic                      queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_partition_count_ff <= PARTITION_BITS'(1);
      end else if (csr_we) begin
         csr_partition_count_ff <= csr_wdata;
      end
   end

   fkp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_hash  (push_hash)
   );

   fkp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_hash (push_hash),
      .pop       (pop),
      .pop_hash  (pop_hash),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   fkp_back #(
      .PARTITION_BITS (PARTITION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .partition_count (csr_partition_count_ff),
      .queue_empty     (queue_empty),
      .queue_hash      (pop_hash),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule
